// ===== rtl/fnv1a_signature_scanner_macros.svh =====
// assertion macros used by the scanner sequencer (fss_ctrl)
// expects a clock named clk and an active-high reset named rst in scope
`ifndef FNV1A_SIGNATURE_SCANNER_MACROS_SVH
`define FNV1A_SIGNATURE_SCANNER_MACROS_SVH

// condition implies consequence in the same cycle
`define FSS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("scanner check failed");

// condition implies consequence in the next cycle
`define FSS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("scanner check failed");

`endif

// ===== rtl/fss_pkg.sv =====
// shared types, constants and the hash step of the signature scanner
// no dependencies
package fss_pkg;

  localparam int MAX_WINDOW_DEF  = 255;
  localparam int OFFSET_BITS_DEF = 32;

  localparam logic [31:0] HASH_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] HASH_PRIME = 32'h0100_0193;

  // configuration register indexes
  localparam logic [1:0] CFG_LEAD_BYTE     = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd1;
  localparam logic [1:0] CFG_TARGET_HASH   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LEADCHK,
    ST_HASH,
    ST_COMPARE,
    ST_FINISH
  } fss_state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic eval;
    logic step;
    logic compare;
    logic finish;
    logic out_load;
  } fss_cmd_t;

  typedef struct packed {
    logic need_hash;
    logic lead_open;
    logic cnt_zero;
    logic last;
    logic out_busy;
  } fss_status_t;

  // one fnv-1a step, product kept modulo 2^32
  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * HASH_PRIME;
  endfunction

endpackage

// ===== rtl/fss_if.sv =====
// request channels of the signature scanner
// depends on nothing
interface fss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;
  logic       last_byte;
  modport source (output valid, scan_byte, last_byte, input ready);
  modport sink (input valid, scan_byte, last_byte, output ready);
endinterface

interface fss_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;
  modport source (output valid, found, match_offset, input ready);
  modport sink (input valid, found, match_offset, output ready);
endinterface

// ===== rtl/fss_ctrl.sv =====
// sequencer of the signature scanner
// depends on fss_pkg and the assertion macros
`include "fnv1a_signature_scanner_macros.svh"

module fss_ctrl
  import fss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  fss_status_t st,
  output fss_cmd_t    cmd
);

  fss_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = st.need_hash ? ST_LEADCHK : ST_FINISH;
      end
      ST_LEADCHK: begin
        if (!st.lead_open) state_next = ST_FINISH;
        else if (st.cnt_zero) state_next = ST_COMPARE;
        else state_next = ST_HASH;
      end
      ST_HASH: begin
        if (st.cnt_zero) state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!(st.last && st.out_busy)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = in_valid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_LEADCHK: begin
        cmd.step = st.lead_open;
      end
      ST_HASH: begin
        cmd.step = 1'b1;
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish   = !(st.last && st.out_busy);
        cmd.out_load = st.last && !st.out_busy;
      end
      default: cmd = '0;
    endcase
  end

  `FSS_ASSERT_NEXT(a_accept_to_eval, cmd.load, state == ST_EVAL)
  `FSS_ASSERT_NOW(a_no_overwrite, cmd.out_load, !st.out_busy)
  `FSS_ASSERT_NEXT(a_hash_end, state == ST_HASH && st.cnt_zero, state == ST_COMPARE)

endmodule

// ===== rtl/fss_dp.sv =====
// datapath: config registers, byte history, hash unit, match and result registers
// depends on fss_pkg
module fss_dp
  import fss_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [7:0]  scan_byte,
  input  logic        last_byte,
  input  logic        out_ready,
  input  fss_cmd_t    cmd,
  output fss_status_t st,
  output logic        out_valid,
  output logic        found,
  output logic [31:0] match_offset
);

  localparam int AW    = (MAX_WINDOW < 2) ? 1 : $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = 1 << AW;
  localparam int OB    = OFFSET_BITS;

  logic [7:0]  lead_byte, window_length;
  logic [31:0] target_hash;

  logic [8:0]    hist [DEPTH];
  logic [8:0]    rd_data;
  logic [AW-1:0] wptr, idx, idx_next, fill;
  logic [7:0]    cnt, span;
  logic [31:0]   hash;
  logic [OB-1:0] pos, match_start;
  logic          match_seen, cur_open, cur_last, zhit;
  logic [OB+31:0] start_ext;

  assign span = window_length - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte     <= 8'd0;
      window_length <= 8'd1;
      target_hash   <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LEAD_BYTE:     lead_byte     <= cfg_data[7:0];
        CFG_WINDOW_LENGTH: window_length <= cfg_data[7:0];
        CFG_TARGET_HASH:   target_hash   <= cfg_data;
        default: ;
      endcase
    end
  end

  // history ring of bytes with their lead flag
  assign idx_next = cmd.load ? (wptr - span[AW-1:0]) : (cmd.step ? idx + 1'b1 : idx);

  always_ff @(posedge clk) begin
    if (cmd.load) hist[wptr] <= {scan_byte == lead_byte, scan_byte};
    rd_data <= hist[idx_next];
    idx     <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_open <= (scan_byte == lead_byte);
      cur_last <= last_byte;
      cnt      <= span;
    end else if (cmd.step) begin
      cnt <= cnt - 8'd1;
    end
    if (cmd.eval) hash <= HASH_BASIS;
    else if (cmd.step) hash <= fnv_mix(hash, rd_data[7:0]);
  end

  assign zhit = !match_seen && (window_length == 8'd0) && cur_open
              && (target_hash == HASH_BASIS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      wptr       <= '0;
      fill       <= '0;
      match_seen <= 1'b0;
    end else if (cmd.compare && hash == target_hash) begin
      match_seen  <= 1'b1;
      match_start <= pos - OB'(span);
    end else if (cmd.finish) begin
      wptr <= wptr + 1'b1;
      if (cur_last) begin
        pos        <= '0;
        fill       <= '0;
        match_seen <= 1'b0;
      end else begin
        pos <= pos + 1'b1;
        if (fill != AW'(MAX_WINDOW)) fill <= fill + 1'b1;
        if (zhit) begin
          match_seen  <= 1'b1;
          match_start <= pos;
        end
      end
    end
  end

  assign start_ext = {32'd0, match_seen ? match_start : pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      found        <= match_seen || zhit;
      match_offset <= (match_seen || zhit) ? start_ext[31:0] : 32'd0;
    end
  end

  assign st.need_hash = !match_seen && (window_length != 8'd0)
                      && (window_length <= 8'(MAX_WINDOW))
                      && (span <= 8'(fill));
  assign st.lead_open = rd_data[8];
  assign st.cnt_zero  = (cnt == 8'd0);
  assign st.last      = cur_last;
  assign st.out_busy  = out_valid && !out_ready;

endmodule

// ===== rtl/fnv1a_signature_scanner.sv =====
// fnv-1a signature scanner, top level
// depends on fss_pkg, fss_if, fss_ctrl and fss_dp
//
// takes a buffer one byte per request on the bytes channel, last_byte marking
// its end, and answers with one request on the result channel per buffer:
// found and the start offset of the earliest window of window_length bytes
// that opens with lead_byte and hashes (fnv-1a, 32 bit) to target_hash.
// bytes are kept in a ring of 2^ceil(log2(MAX_WINDOW+1)) entries; when a
// window completes on the current byte it is rehashed from that ring by a
// single 32x32 multiplier, one byte per cycle. if a window can complete on a
// byte, its start is checked for a lead byte and, if it is one, the hash is
// run and compared. one byte is in flight at a time. the result sits in an
// output register, so scanning of the next buffer goes on while it waits;
// only a further last byte waits for it. the user must write configuration
// via cfg_write/cfg_index/cfg_data only while idle; nothing enforces this.
module fnv1a_signature_scanner
  import fss_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  fss_byte_if.sink     bytes,
  fss_result_if.source result
);

  fss_cmd_t    cmd;
  fss_status_t st;

  // sequencer: steps one byte through eval, lead check, hash loop, compare and finish
  fss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .st       (st),
    .cmd      (cmd)
  );

  assign bytes.ready = cmd.in_ready;

  // datapath: registers, history ring, hash unit and result register
  fss_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .scan_byte    (bytes.scan_byte),
    .last_byte    (bytes.last_byte),
    .out_ready    (result.ready),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (result.valid),
    .found        (result.found),
    .match_offset (result.match_offset)
  );

endmodule

// ===== sim/fnv1a_signature_scanner_tb.sv =====
// self-checking testbench of the fnv-1a signature scanner
// depends on fss_pkg, fss_if and the scanner rtl
`timescale 1ns / 100ps

module fnv1a_signature_scanner_tb;
  import fss_pkg::*;

  localparam int CELLS = 255;
  localparam int SETTLE = 300;          // lets a byte in flight run its hash loop to the end
  localparam int CYCLE_LIMIT = 800000;

  typedef struct {
    bit [7:0] b;
    bit       l;
  } byte_req_t;

  typedef struct {
    bit        found;
    bit [31:0] offset;
  } scan_verdict_t;

  logic clk;
  logic rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  fss_byte_if   bytes_ch();
  fss_result_if result_ch();

  fnv1a_signature_scanner DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .bytes(bytes_ch),
    .result(result_ch)
  );

  // bytes waiting to be sent and verdicts waiting to come back
  byte_req_t     pending_bytes[$];
  scan_verdict_t verdict_q[$];

  int errors = 0;
  int cycles = 0;
  int send_idle = 0;   // percent of cycles the sender holds back
  int recv_stall = 0;  // percent of cycles the receiver holds back
  int sent_total = 0;

  // predictor copy of the registers
  bit [7:0]  cur_lead;
  bit [7:0]  cur_len;
  bit [31:0] cur_target;

  // predictor copy of the scan state
  bit [31:0] win_hash[CELLS];
  bit        win_open[CELLS];
  bit [31:0] next_pos;
  bit        hit_seen;
  bit [31:0] hit_start;

  // signature currently planted in buffers
  bit [7:0] sig[CELLS];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit [31:0] hash_byte(bit [31:0] h, bit [7:0] b);
    return (h ^ {24'd0, b}) * 32'h0100_0193;
  endfunction

  function automatic bit [31:0] sig_digest(int n);
    bit [31:0] h;
    h = HASH_BASIS;
    for (int i = 0; i < n; i++) h = hash_byte(h, sig[i]);
    return h;
  endfunction

  function automatic void clear_scan();
    for (int i = 0; i < CELLS; i++) begin
      win_hash[i] = '0;
      win_open[i] = 1'b0;
    end
    next_pos = '0;
    hit_seen = 1'b0;
    hit_start = '0;
  endfunction

  // advance the predicted scan by one accepted byte
  function automatic void scan_step(bit [7:0] b, bit lst);
    scan_verdict_t v;
    bit opens;
    int span;
    opens = (b == cur_lead);
    // shift the window chain; the oldest window drops out
    for (int i = CELLS - 1; i > 0; i--) begin
      win_hash[i] = win_hash[i-1];
      win_open[i] = win_open[i-1];
    end
    win_hash[0] = HASH_BASIS;
    win_open[0] = opens;
    for (int i = 0; i < CELLS; i++)
      if (win_open[i]) win_hash[i] = hash_byte(win_hash[i], b);
    if (!hit_seen) begin
      if (cur_len == 0) begin
        // empty window completes on its lead byte
        if (opens && cur_target == HASH_BASIS) begin
          hit_seen = 1'b1;
          hit_start = next_pos;
        end
      end else begin
        span = cur_len - 1;
        if (win_open[span] && win_hash[span] == cur_target) begin
          hit_seen = 1'b1;
          hit_start = next_pos - span;
        end
      end
    end
    next_pos = next_pos + 1;
    if (lst) begin
      v.found = hit_seen;
      v.offset = hit_seen ? hit_start : 32'd0;
      verdict_q = {verdict_q, v};
      clear_scan();
    end
  endfunction

  // byte driver; the predictor runs on every accepted request
  always @(posedge clk) begin : drive
    byte_req_t r;
    if (rst) begin
      bytes_ch.valid <= 1'b0;
      bytes_ch.scan_byte <= '0;
      bytes_ch.last_byte <= 1'b0;
    end else begin
      if (bytes_ch.valid && bytes_ch.ready)
        scan_step(bytes_ch.scan_byte, bytes_ch.last_byte);
      if (!bytes_ch.valid || bytes_ch.ready) begin
        if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          r = pending_bytes.pop_front();
          bytes_ch.valid <= 1'b1;
          bytes_ch.scan_byte <= r.b;
          bytes_ch.last_byte <= r.l;
        end else begin
          bytes_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin : watch
    scan_verdict_t v;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
      if (result_ch.valid && result_ch.ready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: found=%0b offset=%0d",
                     result_ch.found, result_ch.match_offset);
        end else begin
          v = verdict_q.pop_front();
          if (result_ch.found !== v.found || result_ch.match_offset !== v.offset) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                       v.found, v.offset, result_ch.found, result_ch.match_offset);
          end
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // wait until the block has drained, then let any byte in flight finish
  task automatic wait_idle();
    @(negedge clk);
    while (pending_bytes.size() > 0 || bytes_ch.valid || verdict_q.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, bit [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_LEAD_BYTE:     cur_lead = val[7:0];
      CFG_WINDOW_LENGTH: cur_len = val[7:0];
      CFG_TARGET_HASH:   cur_target = val;
      default: ;
    endcase
  endtask

  task automatic configure(bit [7:0] lead, bit [7:0] len, bit [31:0] target);
    wait_idle();
    write_reg(CFG_LEAD_BYTE, {24'd0, lead});
    write_reg(CFG_WINDOW_LENGTH, {24'd0, len});
    write_reg(CFG_TARGET_HASH, target);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_byte(bit [7:0] b, bit l);
    byte_req_t r;
    r.b = b;
    r.l = l;
    pending_bytes = {pending_bytes, r};
    sent_total++;
  endtask

  // one buffer: random bytes, extra lead bytes now and then, maybe a planted signature
  task automatic push_buffer(int n, bit plant, int lead_pct);
    bit [7:0] buf_bytes[$];
    int at;
    int slen;
    slen = (cur_len == 0) ? 1 : cur_len;
    for (int i = 0; i < n; i++)
      buf_bytes = {buf_bytes,
                   (($urandom_range(0, 99) < lead_pct) ? cur_lead : 8'($urandom))};
    if (plant && n >= slen) begin
      at = $urandom_range(0, n - slen);
      for (int i = 0; i < slen; i++) buf_bytes[at + i] = sig[i];
    end
    for (int i = 0; i < n; i++) push_byte(buf_bytes[i], i == n - 1);
  endtask

  // sender and receiver idle patterns change with progress
  task automatic pick_idling();
    if (sent_total < 250) begin
      send_idle <= 21;
      recv_stall <= 57;
    end else if (sent_total < 500) begin
      send_idle <= 57;
      recv_stall <= 21;
    end else begin
      send_idle <= 0;
      recv_stall <= 0;
    end
  endtask

  initial begin
    int len;
    bit [31:0] target;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_lead = 8'd0;
    cur_len = 8'd1;
    cur_target = 32'd0;
    clear_scan();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle <= 21;
    recv_stall <= 57;

    // directed: single-byte windows on lead 0x00
    configure(8'h00, 8'd1, hash_byte(HASH_BASIS, 8'h00));
    push_byte(8'h00, 1'b1);                        // one-byte buffer that matches
    push_byte(8'h11, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);                        // earliest start kept
    push_byte(8'hFF, 1'b1);                        // no match

    // directed: zero window length matches on the basis alone
    configure(8'hFF, 8'd0, HASH_BASIS);
    push_byte(8'h10, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);

    // directed: zero length with a different target never matches
    configure(8'hFF, 8'd0, 32'hFFFF_FFFF);
    push_byte(8'hFF, 1'b1);

    // directed: buffer shorter than the window
    sig[0] = 8'h7E; sig[1] = 8'h00; sig[2] = 8'hFF;
    configure(8'h7E, 8'd3, sig_digest(3));
    push_byte(8'h7E, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);                        // exact fit
    push_byte(8'h7E, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b1);                        // second lead starts the match

    // random phases
    for (int ph = 0; sent_total < 680; ph++) begin
      pick_idling();
      if (ph == 4) len = 255;
      else if (ph % 7 == 6) len = 0;
      else len = $urandom_range(1, 12);
      sig[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
      for (int i = 1; i < CELLS; i++) sig[i] = 8'($urandom);
      if ($urandom_range(0, 4) == 0) target = $urandom;
      else target = sig_digest(len);
      configure(sig[0], 8'(len), target);
      if (len == 255) begin
        // longest window: few, long buffers with sparse lead bytes
        push_buffer($urandom_range(255, 270), 1'b1, 0);
        push_buffer($urandom_range(10, 40), 1'b0, 2);
      end else begin
        for (int k = 0; k < 4; k++)
          push_buffer($urandom_range(1, 24), $urandom_range(0, 9) < 6,
                      $urandom_range(0, 25));
      end
    end

    wait_idle();
    if (verdict_q.size() > 0) errors++;
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fss_pkg.sv
rtl/fss_if.sv
rtl/fss_ctrl.sv
rtl/fss_dp.sv
rtl/fnv1a_signature_scanner.sv
sim/fnv1a_signature_scanner_tb.sv
